FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check property p on every clock edge outside reset.
`define ASSERT_CHK(label, clk, rstn, p, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (p)) else $error(msg);

// Check that a implies b in the same cycle.
`define ASSERT_IMP(label, clk, rstn, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

`endif

FILE: design/gfra_pkg.sv
`default_nettype none
package gfra_pkg;
  localparam int unsigned PixelsDef = 1048576;
  localparam int unsigned MaxGapDef = 255;
  localparam int unsigned PixW = 20;
  localparam int unsigned RainW = 16;
  localparam int unsigned SumW = 32;
  localparam int unsigned DurW = 8;

  // Classified item handed from the front to the back part.
  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic [14:0]     rval;
    logic            flagged;
    logic            first;
    logic            last;
  } gfra_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_BASE, ST_FILL, ST_FINISH, ST_OUT
  } gfra_state_e;

  // Saturating duration add.
  function automatic logic [DurW-1:0] dur_sat(input logic [DurW-1:0] d,
                                              input logic [17:0] inc);
    logic [18:0] t;
    t = {11'd0, d} + {1'b0, inc};
    dur_sat = (t > 19'd255) ? 8'hFF : t[7:0];
  endfunction

  // Saturating sum add.
  function automatic logic [SumW-1:0] sum_sat(input logic [SumW-1:0] s,
                                              input logic [SumW:0] inc);
    logic [SumW+1:0] t;
    t = {2'b0, s} + {1'b0, inc};
    sum_sat = (t[SumW+1:SumW] != 2'b0) ? '1 : t[SumW-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: design/gap_filled_rain_accumulator.sv
`default_nettype none
// Channel | Dir | tdata bits (low first)
// s_axis  | in  | pixel[19:0] rain[35:20] first_step[36] last_step[37], pad to 40
// m_axis  | out | pixel_out[19:0] total_mm[35:20] hours_wet[43:36] all_flagged[44]
// An item passes through the idle, read, base and finish states, plus the fill
// state when an inner gap is closed, plus the output state on a last step (held
// while the previous result still waits). Each filled sample needs two divider
// terms of two compare-subtract steps and one add step each.
// Reset clears control only; the pixel store holds no value until first_step.
// The two-entry input queue keeps accepting while the back part or the output
// stalls, until it is full.
module gap_filled_rain_accumulator #(
  parameter int unsigned PIXELS  = gfra_pkg::PixelsDef,
  parameter int unsigned MAX_GAP = gfra_pkg::MaxGapDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // pixel, rain, first_step, last_step
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // pixel_out, total_mm, hours_wet, all_flagged
);
  import gfra_pkg::*;

  gfra_cmd_t q_cmd;
  logic      q_valid, q_ready;

  gfra_front #(.PIXELS(PIXELS)) u_front (
    .clk_i, .rst_ni, .s_tvalid_i(s_tvalid), .s_tready_o(s_tready), .s_tdata_i(s_tdata),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  gfra_back #(.PIXELS(PIXELS), .MAX_GAP(MAX_GAP)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata)
  );
endmodule
`default_nettype wire

FILE: design/gfra_front.sv
`default_nettype none
module gfra_front #(
  parameter int unsigned PIXELS = gfra_pkg::PixelsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_tvalid_i,
  output logic                   s_tready_o,
  input  wire logic [39:0]       s_tdata_i,
  output logic                   q_valid_o,
  input  wire logic              q_ready_i,
  output gfra_pkg::gfra_cmd_t    q_cmd_o
);
  import gfra_pkg::*;
  `include "assert_macros.svh"

  // Two-entry queue toward the back part.
  gfra_cmd_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       in_rng, push, pop;
  gfra_cmd_t  cmd;

  // Classify: drop pixels beyond the store.
  assign in_rng = ({4'd0, s_tdata_i[19:0]} < 24'(PIXELS)) || (PIXELS > 24'hFFFFFF);
  assign cmd.pixel   = s_tdata_i[19:0];
  assign cmd.rval    = s_tdata_i[34:20];
  assign cmd.flagged = s_tdata_i[35];
  assign cmd.first   = s_tdata_i[36];
  assign cmd.last    = s_tdata_i[37];

  assign s_tready_o = (cnt_q != 2'd2);
  assign push = s_tvalid_i && s_tready_o && in_rng;
  assign pop  = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  `ASSERT_CHK(a_cnt_max, clk_i, rst_ni, cnt_q <= 2'd2, "queue count overflow")
  `ASSERT_IMP(a_ptr_eq, clk_i, rst_ni, cnt_q == 2'd0 || cnt_q == 2'd2, wptr_q == rptr_q,
              "queue pointers inconsistent")
  `ASSERT_IMP(a_no_push_full, clk_i, rst_ni, cnt_q == 2'd2, !push, "push into full queue")
endmodule
`default_nettype wire

FILE: design/gfra_back.sv
`default_nettype none
module gfra_back #(
  parameter int unsigned PIXELS  = gfra_pkg::PixelsDef,
  parameter int unsigned MAX_GAP = gfra_pkg::MaxGapDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  output logic                 q_ready_o,
  input  wire gfra_pkg::gfra_cmd_t q_cmd_i,
  output logic                 m_tvalid_o,
  input  wire logic            m_tready_i,
  output logic [47:0]          m_tdata_o
);
  import gfra_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned GW = (MAX_GAP > 1) ? $clog2(MAX_GAP + 1) : 1;
  localparam int unsigned EW = SumW + 16 + GW + DurW;
  localparam int unsigned MW = 17 + GW;

  // Per-pixel state: sum, valid+last good, gap, duration.
  logic [EW-1:0] store [PIXELS];
  logic [EW-1:0] rd_q;

  gfra_state_e st_q, st_d;
  gfra_cmd_t   cmd_q;
  logic [SumW-1:0] sum_q, sum_d;
  logic [DurW-1:0] dur_q, dur_d;
  logic [15:0]     lg_q, lg_d;
  logic [GW-1:0]   gap_q, gap_d;
  logic [GW-1:0]   i_q, i_d;
  logic [47:0]     out_q, out_d;
  logic            ovld_q;
  // Divider state for floor(3*k/(g+1)).
  logic [GW+1:0]   num_q, num_d;
  logic [GW:0]     den_q, den_d;
  logic [1:0]      quo_q, quo_d;
  logic [1:0]      dstep_q, dstep_d;
  logic            dpart_q, dpart_d;
  logic            wr_en;
  logic [SumW-1:0] sum_in;
  logic            vld_in;
  logic [14:0]     v_in;
  logic [GW-1:0]   g_in;
  logic [DurW-1:0] dur_in;
  logic [MW-1:0]   mul;
  logic [SumW:0]   prod;
  logic [SumW+1:0] tot3;
  logic [SumW-8:0] tot;

  // Unpack the read entry, or a cleared one on first step.
  always_comb begin
    if (cmd_q.first) begin
      sum_in = '0; vld_in = 1'b0; v_in = '0; g_in = '0; dur_in = '0;
    end else begin
      {sum_in, vld_in, v_in, g_in, dur_in} = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && q_valid_i) cmd_q <= q_cmd_i;
    rd_q <= store[cmd_q.pixel[AW-1:0]];
    if (wr_en)
      store[cmd_q.pixel[AW-1:0]] <= {sum_q, lg_d, gap_d, dur_q};
    sum_q <= sum_d; dur_q <= dur_d; lg_q <= lg_d; gap_q <= gap_d; i_q <= i_d;
    num_q <= num_d; den_q <= den_d; quo_q <= quo_d; dstep_q <= dstep_d;
    dpart_q <= dpart_d; out_q <= out_d;
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:   if (q_valid_i) st_d = ST_READ;
      ST_READ:   st_d = ST_BASE;
      ST_BASE:   st_d = (!cmd_q.flagged && vld_in && g_in != '0) ? ST_FILL : ST_FINISH;
      ST_FILL:   if (dstep_q == 2'd3 && dpart_q && i_q == gap_q) st_d = ST_FINISH;
      ST_FINISH: st_d = cmd_q.last ? ST_OUT : ST_IDLE;
      ST_OUT:    if (!ovld_q || m_tready_i) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // Datapath per state.
  always_comb begin
    sum_d = sum_q; dur_d = dur_q; lg_d = lg_q; gap_d = gap_q; i_d = i_q;
    num_d = num_q; den_d = den_q; quo_d = quo_q; dstep_d = dstep_q;
    dpart_d = dpart_q; out_d = out_q; wr_en = 1'b0; prod = '0; mul = '0;
    tot3 = '0; tot = '0;
    case (st_q)
      ST_BASE: begin
        sum_d = sum_in; dur_d = dur_in; lg_d = {vld_in, v_in}; gap_d = g_in;
        if (!cmd_q.flagged) begin
          prod = {1'b0, 16'd0, cmd_q.rval, 1'b0};
          sum_d = sum_sat(sum_in, prod);
          if (cmd_q.rval != '0) dur_d = dur_sat(dur_in, 18'd3);
          if (g_in != '0 && !vld_in) begin
            mul = MW'({cmd_q.rval, 1'b0}) * MW'(g_in);
            prod = (SumW+1)'(mul);
            sum_d = sum_sat(sum_sat(sum_in, {1'b0, 16'd0, cmd_q.rval, 1'b0}), prod);
            if (cmd_q.rval != '0)
              dur_d = dur_sat(dur_sat(dur_in, 18'd3), 18'(3 * g_in));
          end else if (g_in != '0) begin
            mul = (MW'(v_in) + MW'(cmd_q.rval)) * MW'(g_in);
            prod = (SumW+1)'(mul);
            sum_d = sum_sat(sum_sat(sum_in, {1'b0, 16'd0, cmd_q.rval, 1'b0}), prod);
          end
        end else if (cmd_q.last) begin
          if (vld_in) begin
            mul = MW'({v_in, 1'b0}) * MW'(g_in);
            prod = (SumW+1)'(mul);
            sum_d = sum_sat(sum_in, prod);
            dur_d = dur_sat(dur_in, 18'(3 * g_in));
          end
        end else if (32'(g_in) < MAX_GAP) begin
          gap_d = g_in + GW'(1);
        end
        // Set up the fill divider: first term i=1, rising part.
        i_d = GW'(1); dpart_d = 1'b0; dstep_d = 2'd0; quo_d = 2'd0;
        num_d = (GW+2)'(3); den_d = {1'b0, g_in} + (GW+1)'(1);
      end
      ST_FILL: begin
        // Restoring divide, one compare-subtract per cycle (quotient <= 3).
        if (dstep_q != 2'd3) begin
          if ({1'b0, num_q} >= {1'b0, den_q, 1'b0} && dstep_q == 2'd0) begin
            num_d = num_q - (GW+2)'({den_q, 1'b0}); quo_d = 2'd2;
          end else if (dstep_q == 2'd1 && (GW+2)'(num_q) >= (GW+2)'(den_q)) begin
            num_d = num_q - (GW+2)'(den_q); quo_d = quo_q + 2'd1;
          end
          dstep_d = (dstep_q == 2'd0) ? 2'd1 : 2'd3;
        end else begin
          if ((!dpart_q && cmd_q.rval != '0) || (dpart_q && lg_q[14:0] != '0))
            dur_d = dur_sat(dur_q, {16'd0, quo_q});
          dstep_d = 2'd0; quo_d = 2'd0;
          if (!dpart_q) begin
            dpart_d = 1'b1;
            num_d = (GW+2)'(3 * (32'(gap_q) - 32'(i_q) + 1));
          end else begin
            dpart_d = 1'b0;
            i_d = i_q + GW'(1);
            num_d = (GW+2)'(3 * (32'(i_q) + 1));
          end
        end
      end
      ST_FINISH: begin
        if (!cmd_q.flagged) begin
          lg_d = {1'b1, cmd_q.rval}; gap_d = '0;
        end
        wr_en = 1'b1;
      end
      ST_OUT: begin
        // Load the result only once the previous one has left.
        if (!ovld_q || m_tready_i) begin
          tot3 = {2'b0, sum_q} + {1'b0, sum_q, 1'b0} + (SumW+2)'(256);
          tot = tot3[SumW+1:9];
          out_d[19:0] = cmd_q.pixel;
          if (lg_q[15]) begin
            out_d[35:20] = (tot > 25'd32767) ? 16'h7FFF : tot[15:0];
            out_d[44] = 1'b0;
          end else begin
            out_d[35:20] = '0;
            out_d[44] = 1'b1;
          end
          out_d[43:36] = dur_q;
          out_d[47:45] = '0;
        end
      end
      default: ;
    endcase
  end

  assign q_ready_o  = (st_q == ST_IDLE);
  assign m_tvalid_o = ovld_q;
  assign m_tdata_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ovld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_OUT && (!ovld_q || m_tready_i)) ovld_q <= 1'b1;
      else if (m_tready_i) ovld_q <= 1'b0;
    end
  end

  `ASSERT_IMP(a_fill_gap, clk_i, rst_ni, st_q == ST_FILL, gap_q != '0 && i_q <= gap_q,
              "fill index out of range")
  `ASSERT_IMP(a_quo, clk_i, rst_ni, st_q == ST_FILL, quo_q <= 2'd3, "fill quotient overflow")
  `ASSERT_IMP(a_ready_idle, clk_i, rst_ni, q_ready_o, st_q == ST_IDLE, "ready outside idle")
endmodule
`default_nettype wire

FILE: verif/rain_checker.sv
`default_nettype none
module rain_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [47:0] m_tdata,
  output int               errors_o,
  output int               pending_o
);
  import gfra_pkg::*;

  typedef struct packed {
    logic             all_flagged;
    logic [DurW-1:0]  hours;
    logic [RainW-1:0] total;
    logic [PixW-1:0]  pixel;
  } pixel_total_t;

  // Per-pixel accumulation state, cleared on first_step or on a pixel's first item
  logic [SumW-1:0] acc_sum [int unsigned];
  logic [16:0]     last_good [int unsigned];
  int unsigned     gap_cnt [int unsigned];
  logic [DurW-1:0] wet_hours [int unsigned];

  pixel_total_t totals_q[$];

  assign pending_o = totals_q.size();

  function automatic logic [DurW-1:0] add_hours(logic [DurW-1:0] d, longint unsigned inc);
    longint unsigned t;
    t = d + inc;
    return (t > 255) ? 8'hFF : t[7:0];
  endfunction

  function automatic logic [SumW-1:0] add_sum(logic [SumW-1:0] s, longint unsigned inc);
    longint unsigned t;
    t = s + inc;
    return (t > 64'hFFFF_FFFF) ? '1 : t[31:0];
  endfunction

  // Advance one pixel's state and queue its total on a last step
  task automatic accumulate(logic [39:0] d);
    int unsigned px;
    longint unsigned r, v, g;
    logic flagged, first, last, seen;
    logic [SumW-1:0] s;
    logic [DurW-1:0] h;
    logic [16:0] lg;
    longint unsigned t;
    pixel_total_t res;
    px = d[19:0];
    r = d[34:20];
    flagged = d[35];
    first = d[36];
    last = d[37];
    if (first || !acc_sum.exists(px)) begin
      acc_sum[px] = '0;
      last_good[px] = '0;
      gap_cnt[px] = 0;
      wet_hours[px] = '0;
    end
    s = acc_sum[px];
    lg = last_good[px];
    g = gap_cnt[px];
    h = wet_hours[px];
    seen = lg[16];
    v = lg[14:0];
    if (!flagged) begin
      s = add_sum(s, 2 * r);
      if (r > 0) h = add_hours(h, 3);
      if (g > 0) begin
        if (!seen) begin
          // leading gap copies the sample
          s = add_sum(s, 2 * r * g);
          if (r > 0) h = add_hours(h, 3 * g);
        end else begin
          // inner gap: linear interpolation between v and r
          s = add_sum(s, g * (v + r));
          for (longint unsigned i = 1; i <= g; i++) begin
            if (r > 0) h = add_hours(h, (3 * i) / (g + 1));
            if (v > 0) h = add_hours(h, (3 * (g - i + 1)) / (g + 1));
          end
        end
      end
      lg = {1'b1, 1'b0, r[14:0]};
      g = 0;
      seen = 1'b1;
    end else if (last) begin
      // trailing gap holds the last good value
      if (seen) begin
        s = add_sum(s, 2 * v * g);
        h = add_hours(h, 3 * g);
      end
    end else if (g < MaxGapDef) begin
      g++;
    end
    acc_sum[px] = s;
    last_good[px] = lg;
    gap_cnt[px] = g;
    wet_hours[px] = h;
    if (last) begin
      res.pixel = px[19:0];
      res.hours = h;
      res.all_flagged = !seen;
      if (seen) begin
        t = (3 * longint'(s) + 256) >> 9;
        res.total = (t > 32767) ? 16'h7FFF : t[15:0];
      end else begin
        res.total = '0;
      end
      totals_q.push_back(res);
    end
  endtask

  // Predict on input items, compare output items
  always @(posedge clk_i) begin
    pixel_total_t got, want;
    if (rst_ni) begin
      if (s_tvalid && s_tready) accumulate(s_tdata);
      if (m_tvalid && m_tready) begin
        got = m_tdata[44:0];
        if (totals_q.size() == 0) begin
          $display("%0t: unexpected item %h", $realtime, got);
          errors_o++;
        end else begin
          want = totals_q.pop_front();
          if (got.pixel !== want.pixel) begin
            $display("%0t: pixel_out exp %h got %h", $realtime, want.pixel, got.pixel);
            errors_o++;
          end
          if (got.total !== want.total) begin
            $display("%0t: total_mm exp %h got %h", $realtime, want.total, got.total);
            errors_o++;
          end
          if (got.hours !== want.hours) begin
            $display("%0t: hours_wet exp %h got %h", $realtime, want.hours, got.hours);
            errors_o++;
          end
          if (got.all_flagged !== want.all_flagged) begin
            $display("%0t: all_flagged exp %b got %b", $realtime, want.all_flagged,
                     got.all_flagged);
            errors_o++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none
module testbench;
  localparam int Limit = 2000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  int          errors, pending;
  int          send_idle_pct = 0, stall_pct = 0, hold_cycles = 0;
  int          cycles = 0;
  int unsigned live_px[$];

  gap_filled_rain_accumulator dut (.*);

  rain_checker checker_i (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .errors_o(errors), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Drive ready: long hold-off when asked, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_sample(int unsigned px, logic [15:0] rain, bit first, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, last, first, rain, px[19:0]};
    do @(posedge clk_i); while (!s_tready);
  endtask

  function automatic logic [15:0] good_rain();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return {1'b0, 15'($urandom_range(40))};
      default: return {1'b0, 15'($urandom)};
    endcase
  endfunction

  function automatic logic [15:0] bad_rain();
    return {1'b1, 15'($urandom)};
  endfunction

  // One compositing period for a pixel, with random gaps
  task automatic send_period(int unsigned px);
    int n, gap;
    n = $urandom_range(8, 1);
    send_sample(px, ($urandom_range(2) == 0) ? bad_rain() : good_rain(), 1'b1, n == 1);
    for (int k = 2; k <= n; k++) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(4) : 0;
      for (int j = 0; j < gap; j++) send_sample(px, bad_rain(), 1'b0, 1'b0);
      send_sample(px, ($urandom_range(3) == 0) ? bad_rain() : good_rain(), 1'b0, k == n);
    end
    live_px.push_back(px);
  endtask

  task automatic random_phase(int periods);
    int unsigned px;
    for (int p = 0; p < periods; p++) begin
      if ($urandom_range(4) == 0 && live_px.size() > 0) begin
        // noise: stray samples on already started pixels
        px = live_px[$urandom_range(live_px.size() - 1)];
        send_sample(px, 16'($urandom), 1'b0, 1'($urandom_range(1)));
      end else begin
        send_period($urandom_range(3) == 0 ? $urandom_range(7) : $urandom_range(20'hFFFFF));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, leading/inner/trailing gaps, all flagged
    send_sample(0, 16'h7FFF, 1'b1, 1'b1);
    send_sample(20'hFFFFF, 16'h8000, 1'b1, 1'b0);
    send_sample(20'hFFFFF, 16'hFFFF, 1'b0, 1'b1);
    send_sample(1, 16'h8001, 1'b1, 1'b0);
    send_sample(1, 16'h8001, 1'b0, 1'b0);
    send_sample(1, 16'h0100, 1'b0, 1'b0);
    send_sample(1, 16'hFFFF, 1'b0, 1'b0);
    send_sample(1, 16'hFFFF, 1'b0, 1'b0);
    send_sample(1, 16'h0000, 1'b0, 1'b0);
    send_sample(1, 16'h9000, 1'b0, 1'b0);
    send_sample(1, 16'h7FFF, 1'b0, 1'b1);
    send_sample(2, 16'h0040, 1'b1, 1'b0);
    send_sample(2, 16'h8000, 1'b0, 1'b0);
    send_sample(2, 16'h8000, 1'b0, 1'b1);
    send_sample(3, 16'h0000, 1'b1, 1'b0);
    send_sample(3, 16'h8000, 1'b0, 1'b0);
    send_sample(3, 16'h0000, 1'b0, 1'b1);
    send_sample(20'hAAAAA, 16'h5555, 1'b1, 1'b1);
    send_sample(20'h55555, 16'h2AAA, 1'b1, 1'b1);
    // Inner gap longer than the gap counter's saturation value of 255
    send_sample(4, 16'h0123, 1'b1, 1'b0);
    for (int j = 0; j < 260; j++) send_sample(4, bad_rain(), 1'b0, 1'b0);
    send_sample(4, 16'h0040, 1'b0, 1'b1);
    live_px = '{0, 1, 2, 3, 4, 20'hFFFFF};

    random_phase(5);
    send_idle_pct = 84;
    random_phase(5);
    send_idle_pct = 0;
    stall_pct = 84;
    random_phase(5);
    send_idle_pct = 37;
    stall_pct = 37;
    random_phase(5);
    // Back pressure: output blocked while input keeps coming
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 400;
    for (int k = 0; k < 30; k++) send_sample(k, good_rain(), 1'b1, 1'b1);
    random_phase(4);
    s_tvalid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
